// ===== rtl/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants of the trial-division primality tester.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  // Width of the candidate field on the input stream.
  localparam int CAND_BITS = 32;
  // Width of the result stream data, one flag padded to a byte.
  localparam int RES_BITS = 8;
  // Trial divisors start here.
  localparam int FIRST_DIVISOR = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new candidate and start dividing by two
    logic step;  // one restoring division step
    logic next;  // advance to the next divisor and restart the division
  } tdpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_lt2;       // candidate is zero or one
    logic div_last;    // the current step is the last one of the division
    logic bound_fail;  // divisor exceeds the quotient, so d*d > n
    logic rem_zero;    // remainder of the finished division is zero
  } tdpt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tdpt_dp.sv =====
// ----------------------------------------------------------------------------
// tdpt_dp
// Datapath: candidate and divisor registers with a radix-2 restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_dp #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [tdpt_pkg::CAND_BITS-1:0] cand_i,
  input  wire tdpt_pkg::tdpt_cmd_t         cmd_i,
  output tdpt_pkg::tdpt_sts_t              sts_o
);

  import tdpt_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] n_in;
  logic [VALUE_BITS-1:0] n_q;
  logic [VALUE_BITS-1:0] d_q;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  fits;

  // Bits above the configured width are dropped.
  assign n_in = VALUE_BITS'(cand_i);

  // The remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, d_q};
  assign fits    = !diff[VALUE_BITS];

  always_comb begin
    rem_d = fits ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
    quo_d = {quo_q[VALUE_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load || cmd_i.next) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= n_in;
      d_q   <= VALUE_BITS'(FIRST_DIVISOR);
      quo_q <= n_in;
      rem_q <= '0;
    end else if (cmd_i.next) begin
      d_q   <= d_q + VALUE_BITS'(1);
      quo_q <= n_q;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    sts_o.n_lt2      = n_q < VALUE_BITS'(FIRST_DIVISOR);
    sts_o.div_last   = cnt_q == CNT_W'(VALUE_BITS - 1);
    sts_o.bound_fail = d_q > quo_q;
    sts_o.rem_zero   = rem_q == '0;
  end

endmodule

`default_nettype wire

// ===== rtl/tdpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences divisions per candidate and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     prime_o,
  output tdpt_pkg::tdpt_cmd_t      cmd_o,
  input  wire tdpt_pkg::tdpt_sts_t sts_i
);

  import tdpt_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    CHECK
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   prime_q;
  logic   out_free;
  logic   done;
  logic   verdict;
  logic   res_load;

  assign out_free = !out_valid_q || out_ready_i;
  assign done     = sts_i.n_lt2 || sts_i.bound_fail || sts_i.rem_zero;
  // Once the divisor passes the quotient, no factor is left to find.
  assign verdict  = !sts_i.n_lt2 && sts_i.bound_fail;
  assign res_load = (state_q == CHECK) && done && out_free;

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      DIVIDE: begin
        cmd_o.step = 1'b1;
      end
      CHECK: begin
        cmd_o.next = !done;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      out_valid_q <= 1'b0;
      prime_q     <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
        prime_q     <= verdict;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            state_q <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (sts_i.div_last) begin
            state_q <= CHECK;
          end
        end
        CHECK: begin
          if (!done) begin
            state_q <= DIVIDE;
          end else if (out_free) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign prime_o     = prime_q;

endmodule

`default_nettype wire

// ===== rtl/trial_division_primality_test.sv =====
// Each trial divisor takes a full bit-serial division and then a check, after
// the candidate is accepted; up to about 2^(VALUE_BITS/2) divisors per candidate.
// Throughput: one candidate at a time; the next is accepted as soon as the
// result is in the output register, even while that result waits.
// Reset: rst_ni is asynchronous and active low; it empties the output register
// and returns the controller to idle.
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Streams candidates in and reports for each whether it is prime.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_primality_test #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [tdpt_pkg::CAND_BITS-1:0] s_axis_tdata_i,  // [31:0] candidate
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [tdpt_pkg::RES_BITS-1:0]      m_axis_tdata_o    // [0] prime flag, [7:1] zero
);

  import tdpt_pkg::*;

  tdpt_cmd_t cmd;
  tdpt_sts_t sts;
  logic      prime_flag;

  tdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .prime_o     (prime_flag),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tdpt_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cand_i (s_axis_tdata_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign m_axis_tdata_o = {{(RES_BITS-1){1'b0}}, prime_flag};

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.next}))
    else $error("datapath commands overlap");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted again before the test finished");

  a_div_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step && sts.div_last) |=> !cmd.step)
    else $error("divider stepped past its last bit");

  a_next_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.next |=> cmd.step)
    else $error("new divisor not followed by a division");

endmodule

`default_nettype wire

// ===== sim/tdpt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdpt_checker
// Watches both streams of the primality tester, works out by trial division
// whether each accepted candidate is prime, and compares the result stream
// against those verdicts in order.
// ----------------------------------------------------------------------------

module tdpt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [tdpt_pkg::CAND_BITS-1:0] s_tdata_i,   // [31:0] candidate
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [tdpt_pkg::RES_BITS-1:0]  m_tdata_i,   // [0] prime flag, [7:1] zero
  output int                            fail_cnt_o,
  output int                            pending_o
);

  typedef struct {
    logic [tdpt_pkg::CAND_BITS-1:0] candidate;
    logic                           prime;
  } verdict_t;

  verdict_t verdicts_due[$];
  verdict_t oldest;

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  // Divisors run upward from the first one while d <= n / d, so the bound
  // never needs a product that could overflow.
  function automatic logic divides_to_prime(input logic [tdpt_pkg::CAND_BITS-1:0] n);
    logic [tdpt_pkg::CAND_BITS-1:0] d;
    if (n < tdpt_pkg::FIRST_DIVISOR) return 1'b0;
    d = tdpt_pkg::FIRST_DIVISOR;
    while (d <= n / d) begin
      if (n % d == 0) return 1'b0;
      d++;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // The result side is handled first: no result can leave in the same
      // cycle as its own candidate is taken.
      if (m_tvalid_i && m_tready_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result %0b with no candidate outstanding",
                                    m_tdata_i[0]));
        end else begin
          oldest = verdicts_due.pop_front();
          if (m_tdata_i[0] !== oldest.prime)
            report_mismatch($sformatf("candidate %0d: prime flag %b, expected %b",
                                      oldest.candidate, m_tdata_i[0], oldest.prime));
        end
      end
      if (s_tvalid_i && s_tready_i)
        verdicts_due.push_back('{s_tdata_i, divides_to_prime(s_tdata_i)});
      pending_o = verdicts_due.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives candidates into the primality tester: first the edge values and
// the squares of primes at the divisor bound, then random candidates kept
// cheap to test, under several patterns of idle and stall on both streams.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int VALUE_BITS   = 32;
  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4 * (VALUE_BITS + 1);
  localparam int ITEMS_PER_PHASE = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tdpt_pkg::CAND_BITS-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tdpt_pkg::RES_BITS-1:0]  m_tdata;

  int fail_cnt;
  int pending;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  logic [31:0] directed_values[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd97, 32'd121,
    32'd63001,        // 251 squared, divisor reaches the bound exactly
    32'd65521, 32'd65535,
    32'd1018081,      // 1009 squared
    32'd16752649,     // 4093 squared
    32'd16777213,
    32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  trial_division_primality_test #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  tdpt_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // Result side: random stalls, or a long hold-off on request so that the
  // output register fills and the input stream backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic offer_candidate(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Large values always carry a small factor, so every bit gets exercised
  // without letting the divisor loop run toward its worst case.
  function automatic logic [31:0] random_candidate();
    int unsigned pick;
    logic [31:0] raw;
    logic [31:0] factor;
    pick = $urandom_range(99);
    raw  = $urandom();
    if (pick < 10) return $urandom_range(15);
    if (pick < 60) return $urandom_range(65535);
    if (pick < 94) begin
      factor = $urandom_range(64, 2);
      return raw - raw % factor;
    end
    return $urandom_range((1 << 20) - 1);
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed candidates at full rate, opened by a long result hold-off.
    hold_req = 1'b1;
    foreach (directed_values[i]) offer_candidate(directed_values[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      repeat (ITEMS_PER_PHASE) offer_candidate(random_candidate());
    end
    s_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tdpt_pkg.sv
rtl/tdpt_dp.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_primality_test.sv
sim/tdpt_checker.sv
sim/tb_top.sv
